### src/fodsm_pkg.sv
// Package for the fourth-order delta-sigma modulator: register map, reset
// constants, microcode word layout and the microcode program itself.
// No dependencies; used by fodsm_mul and the top-level modulator.
`default_nettype none

package fodsm_pkg;

	// Default datapath sizing for the integrators.
	localparam int DEF_STATE_WIDTH     = 32;
	localparam int DEF_STATE_FRAC_BITS = 24;

	// Configuration registers: all are unsigned Q1.16.
	localparam int COEF_W    = 17;
	localparam int PCM_W     = 16;
	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INPUT_GAIN = 3'd0,
		REG_COEF_A1    = 3'd1,
		REG_COEF_A2    = 3'd2,
		REG_COEF_A3    = 3'd3,
		REG_COEF_A4    = 3'd4,
		REG_COEF_B1    = 3'd5,
		REG_COEF_C1    = 3'd6
	} cfg_idx_t;

	localparam logic [COEF_W-1:0] RST_INPUT_GAIN = 17'd52429;
	localparam logic [COEF_W-1:0] RST_COEF_A1    = 17'd21845;
	localparam logic [COEF_W-1:0] RST_COEF_A2    = 17'd7864;
	localparam logic [COEF_W-1:0] RST_COEF_A3    = 17'd6554;
	localparam logic [COEF_W-1:0] RST_COEF_A4    = 17'd6554;
	localparam logic [COEF_W-1:0] RST_COEF_B1    = 17'd78643;
	localparam logic [COEF_W-1:0] RST_COEF_C1    = 17'd10923;

	// Integrator reset values in Q8.24; rescaled to the configured format.
	localparam logic signed [31:0] RST_I1_Q24 = 32'sd2240497;
	localparam logic signed [31:0] RST_I2_Q24 = -32'sd671173;
	localparam logic signed [31:0] RST_I3_Q24 = -32'sd253554;
	localparam logic signed [31:0] RST_I4_Q24 = -32'sd312006;

	// Microcode word fields.
	typedef enum logic [1:0] {
		MS_XS,
		MS_I4,
		MS_ACC,
		MS_I1
	} mul_src_t;

	typedef enum logic [2:0] {
		CS_GAIN,
		CS_A1,
		CS_A2,
		CS_A3,
		CS_A4,
		CS_B1,
		CS_C1
	} coef_sel_t;

	typedef enum logic [1:0] {
		OA_PROD,
		OA_ACC,
		OA_I2
	} opa_t;

	typedef enum logic [2:0] {
		OB_ZERO,
		OB_FB,
		OB_T,
		OB_I1,
		OB_I2,
		OB_I3,
		OB_I4
	} opb_t;

	typedef enum logic [2:0] {
		DST_NONE,
		DST_ACC,
		DST_T,
		DST_I1,
		DST_I2,
		DST_I3,
		DST_I4
	} dst_t;

	typedef struct packed {
		mul_src_t  mul_src;
		coef_sel_t coef;
		opa_t      opa;
		opb_t      opb;
		logic      sub;
		dst_t      dst;
		logic      last;
	} ucode_t;

	localparam int PROG_LEN = 13;
	localparam int STEP_W   = $clog2(PROG_LEN);

	// The program. The multiplier result is registered in the product register,
	// so each product is consumed in the step after the one that issues its
	// multiply.
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		w = '{mul_src: MS_XS, coef: CS_GAIN, opa: OA_PROD, opb: OB_ZERO,
			sub: 1'b0, dst: DST_NONE, last: 1'b0};
		case (step)
			// Scaled input x.
			STEP_W'(0): begin
				w.mul_src = MS_XS;
				w.coef    = CS_GAIN;
			end
			// acc = x - fb, issue old integ_four times c1.
			STEP_W'(1): begin
				w.opa     = OA_PROD;
				w.opb     = OB_FB;
				w.sub     = 1'b1;
				w.dst     = DST_ACC;
				w.mul_src = MS_I4;
				w.coef    = CS_C1;
			end
			// Keep the resonator term, issue (x - fb) times a1.
			STEP_W'(2): begin
				w.opa     = OA_PROD;
				w.opb     = OB_ZERO;
				w.dst     = DST_T;
				w.mul_src = MS_ACC;
				w.coef    = CS_A1;
			end
			STEP_W'(3): begin
				w.opa = OA_PROD;
				w.opb = OB_I1;
				w.dst = DST_I1;
			end
			STEP_W'(4): begin
				w.mul_src = MS_I1;
				w.coef    = CS_A2;
			end
			STEP_W'(5): begin
				w.opa = OA_PROD;
				w.opb = OB_I2;
				w.dst = DST_I2;
			end
			// acc = integ_two - c1 term.
			STEP_W'(6): begin
				w.opa = OA_I2;
				w.opb = OB_T;
				w.sub = 1'b1;
				w.dst = DST_ACC;
			end
			// Issue acc times a3, and park integ_two - fb for the last sum.
			STEP_W'(7): begin
				w.mul_src = MS_ACC;
				w.coef    = CS_A3;
				w.opa     = OA_I2;
				w.opb     = OB_FB;
				w.sub     = 1'b1;
				w.dst     = DST_T;
			end
			STEP_W'(8): begin
				w.opa     = OA_PROD;
				w.opb     = OB_I3;
				w.dst     = DST_I3;
				w.mul_src = MS_I1;
				w.coef    = CS_B1;
			end
			STEP_W'(9): begin
				w.opa = OA_PROD;
				w.opb = OB_I3;
				w.dst = DST_ACC;
			end
			STEP_W'(10): begin
				w.opa = OA_ACC;
				w.opb = OB_T;
				w.dst = DST_ACC;
			end
			STEP_W'(11): begin
				w.mul_src = MS_ACC;
				w.coef    = CS_A4;
			end
			STEP_W'(12): begin
				w.opa  = OA_PROD;
				w.opb  = OB_I4;
				w.dst  = DST_I4;
				w.last = 1'b1;
			end
			default: begin
				w.last = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### src/fodsm_mul.sv
// Shared coefficient multiplier: floor(v * c / 2^16) with a registered result.
// Depends on fodsm_pkg for the coefficient width.
`default_nettype none

module fodsm_mul
	import fodsm_pkg::*;
#(
	parameter int DW = DEF_STATE_WIDTH + 4
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [DW-1:0] op,
	input  wire logic [COEF_W-1:0]    coef,
	output logic signed [DW-1:0]      prod_q
);

	logic signed [DW-17:0]  hi;
	logic [15:0]            lo;
	logic signed [DW+1:0]   hi_prod;
	logic [32:0]            lo_prod;
	logic signed [DW-1:0]   prod_d;

	// Split the operand so the wide part multiplies as a signed word and the
	// low half contributes only its floored top bits.
	assign hi      = op[DW-1:16];
	assign lo      = op[15:0];
	assign hi_prod = hi * $signed({1'b0, coef});
	assign lo_prod = lo * coef;
	assign prod_d  = hi_prod[DW-1:0] + {{(DW-17){1'b0}}, lo_prod[32:16]};

	// Product register.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= prod_d;
		end
	end

endmodule

`default_nettype wire

### src/fourth_order_delta_sigma_modulator.sv
// Fourth-order one-bit delta-sigma modulator, PCM in, DSD out.
// Depends on fodsm_pkg and fodsm_mul.
//
//   Channel   Direction  Handshake                  Payload
//   s_*       in         tvalid/tready              tdata[15:0] pcm_sample
//   m_*       out        tvalid/tready              tdata[0] dsd_bit
//   APB       in/out     psel/penable/pwrite/pready coefficient registers
//
// Each sample runs the 13-step microcode program; its length is set by the
// dependency chain of the four integrator updates through one shared multiplier.
// A new sample is accepted in the cycle after the previous one finishes.
// The result waits in an output register; the next sample runs meanwhile, and
// only its final step holds while that register is still full.
// Reset restores the coefficient defaults and the integrator start values.
`default_nettype none

module fourth_order_delta_sigma_modulator
	import fodsm_pkg::*;
#(
	parameter int STATE_WIDTH     = DEF_STATE_WIDTH,
	parameter int STATE_FRAC_BITS = DEF_STATE_FRAC_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Input stream.
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [15:0]       s_tdata,  // [15:0] pcm_sample
	// Output stream.
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [7:0]             m_tdata,  // [0] dsd_bit, [7:1] zero
	// Configuration port.
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	localparam int W  = STATE_WIDTH;
	localparam int F  = STATE_FRAC_BITS;
	localparam int DW = ((W > F + 2) ? W : F + 2) + 4;
	localparam int UP_SH = (F >= 24) ? F - 24 : 0;
	localparam int DN_SH = (F >= 24) ? 0 : 24 - F;

	localparam logic signed [DW-1:0] FB_ONE = {{(DW-1){1'b0}}, 1'b1} << F;
	localparam logic signed [DW-1:0] FB_NEG = -FB_ONE;
	localparam logic signed [DW-1:0] SAT_HI = {{(DW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [DW-1:0] SAT_LO = ~SAT_HI;

	// Rescale a Q8.24 start value to the state format (floor) and saturate.
	function automatic logic [W-1:0] init_state(input logic signed [31:0] q24);
		logic signed [63:0] v;
		logic signed [63:0] lim;
		v   = {{32{q24[31]}}, q24};
		lim = (64'sd1 <<< (W - 1)) - 64'sd1;
		if (F >= 24) begin
			v = v <<< UP_SH;
		end else begin
			v = v >>> DN_SH;
		end
		if (v > lim) begin
			v = lim;
		end else if (v < -lim - 64'sd1) begin
			v = -lim - 64'sd1;
		end
		return v[W-1:0];
	endfunction

	localparam logic [W-1:0] I1_INIT = init_state(RST_I1_Q24);
	localparam logic [W-1:0] I2_INIT = init_state(RST_I2_Q24);
	localparam logic [W-1:0] I3_INIT = init_state(RST_I3_Q24);
	localparam logic [W-1:0] I4_INIT = init_state(RST_I4_Q24);

	// Saturate a datapath value to the integrator range.
	function automatic logic [W-1:0] sat_w(input logic signed [DW-1:0] v);
		logic [W-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[W-1:0];
		end else begin
			r = v[W-1:0];
		end
		return r;
	endfunction

	// Sign-extend an integrator to the datapath width.
	function automatic logic signed [DW-1:0] ext_w(input logic [W-1:0] v);
		return {{(DW-W){v[W-1]}}, v};
	endfunction

	logic [COEF_W-1:0] input_gain_q, coef_a1_q, coef_a2_q, coef_a3_q;
	logic [COEF_W-1:0] coef_a4_q, coef_b1_q, coef_c1_q;
	logic              cfg_wr;
	cfg_idx_t          cfg_idx;

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic              m_valid_q;
	logic              dsd_q;
	logic [PCM_W-1:0]  pcm_q;
	logic [W-1:0]      i1_q, i2_q, i3_q, i4_q;
	logic signed [DW-1:0] acc_q, t_q;

	ucode_t               uw;
	logic                 accept;
	logic                 slot_free;
	logic                 run;
	logic                 fb_pos;
	logic signed [DW-1:0] fb;
	logic signed [DW-1:0] xs;
	logic signed [DW-1:0] mul_op;
	logic [COEF_W-1:0]    mul_coef;
	logic signed [DW-1:0] prod;
	logic signed [DW-1:0] alu_a, alu_b, alu_res;
	logic [W-1:0]         sat_res;

	// Configuration register writes.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = cfg_idx_t'(paddr[APB_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_gain_q <= RST_INPUT_GAIN;
			coef_a1_q    <= RST_COEF_A1;
			coef_a2_q    <= RST_COEF_A2;
			coef_a3_q    <= RST_COEF_A3;
			coef_a4_q    <= RST_COEF_A4;
			coef_b1_q    <= RST_COEF_B1;
			coef_c1_q    <= RST_COEF_C1;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_INPUT_GAIN: input_gain_q <= pwdata[COEF_W-1:0];
				REG_COEF_A1:    coef_a1_q    <= pwdata[COEF_W-1:0];
				REG_COEF_A2:    coef_a2_q    <= pwdata[COEF_W-1:0];
				REG_COEF_A3:    coef_a3_q    <= pwdata[COEF_W-1:0];
				REG_COEF_A4:    coef_a4_q    <= pwdata[COEF_W-1:0];
				REG_COEF_B1:    coef_b1_q    <= pwdata[COEF_W-1:0];
				REG_COEF_C1:    coef_c1_q    <= pwdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back; unaligned addresses read as zero.
	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			unique case (cfg_idx)
				REG_INPUT_GAIN: prdata = {{(APB_DW-COEF_W){1'b0}}, input_gain_q};
				REG_COEF_A1:    prdata = {{(APB_DW-COEF_W){1'b0}}, coef_a1_q};
				REG_COEF_A2:    prdata = {{(APB_DW-COEF_W){1'b0}}, coef_a2_q};
				REG_COEF_A3:    prdata = {{(APB_DW-COEF_W){1'b0}}, coef_a3_q};
				REG_COEF_A4:    prdata = {{(APB_DW-COEF_W){1'b0}}, coef_a4_q};
				REG_COEF_B1:    prdata = {{(APB_DW-COEF_W){1'b0}}, coef_b1_q};
				REG_COEF_C1:    prdata = {{(APB_DW-COEF_W){1'b0}}, coef_c1_q};
				default:        prdata = '0;
			endcase
		end
	end

	// Sequencer control: the final step waits until the output slot is free.
	assign uw        = ucode_rom(step_q);
	assign s_tready  = !busy_q;
	assign accept    = s_tvalid && s_tready;
	assign slot_free = !m_valid_q || m_tready;
	assign run       = busy_q && (!uw.last || slot_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			step_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (run) begin
				if (uw.last) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
			if (run && uw.last) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Sample capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			pcm_q <= s_tdata;
		end
	end

	// Feedback comes from integ_four, which changes only in the last step.
	assign fb_pos = ($signed(i4_q) > 0);
	assign fb     = fb_pos ? FB_ONE : FB_NEG;
	assign xs     = {{(DW-PCM_W){pcm_q[PCM_W-1]}}, pcm_q} <<< (F - 15);

	// Multiplier operand selection.
	always_comb begin
		case (uw.mul_src)
			MS_XS:   mul_op = xs;
			MS_I4:   mul_op = ext_w(i4_q);
			MS_ACC:  mul_op = acc_q;
			MS_I1:   mul_op = ext_w(i1_q);
			default: mul_op = xs;
		endcase
		case (uw.coef)
			CS_GAIN: mul_coef = input_gain_q;
			CS_A1:   mul_coef = coef_a1_q;
			CS_A2:   mul_coef = coef_a2_q;
			CS_A3:   mul_coef = coef_a3_q;
			CS_A4:   mul_coef = coef_a4_q;
			CS_B1:   mul_coef = coef_b1_q;
			CS_C1:   mul_coef = coef_c1_q;
			default: mul_coef = input_gain_q;
		endcase
	end

	fodsm_mul #(
		.DW (DW)
	) u_mul (
		.clk    (clk),
		.en     (run),
		.op     (mul_op),
		.coef   (mul_coef),
		.prod_q (prod)
	);

	// Adder with operand selection; integrator results saturate.
	always_comb begin
		case (uw.opa)
			OA_PROD: alu_a = prod;
			OA_ACC:  alu_a = acc_q;
			OA_I2:   alu_a = ext_w(i2_q);
			default: alu_a = prod;
		endcase
		case (uw.opb)
			OB_ZERO: alu_b = '0;
			OB_FB:   alu_b = fb;
			OB_T:    alu_b = t_q;
			OB_I1:   alu_b = ext_w(i1_q);
			OB_I2:   alu_b = ext_w(i2_q);
			OB_I3:   alu_b = ext_w(i3_q);
			OB_I4:   alu_b = ext_w(i4_q);
			default: alu_b = '0;
		endcase
	end

	assign alu_res = uw.sub ? alu_a - alu_b : alu_a + alu_b;
	assign sat_res = sat_w(alu_res);

	// Integrator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i1_q <= I1_INIT;
			i2_q <= I2_INIT;
			i3_q <= I3_INIT;
			i4_q <= I4_INIT;
		end else if (run) begin
			unique case (uw.dst)
				DST_I1:  i1_q <= sat_res;
				DST_I2:  i2_q <= sat_res;
				DST_I3:  i3_q <= sat_res;
				DST_I4:  i4_q <= sat_res;
				default: ;
			endcase
		end
	end

	// Scratch registers and the output bit.
	always_ff @(posedge clk) begin
		if (run) begin
			unique case (uw.dst)
				DST_ACC: acc_q <= alu_res;
				DST_T:   t_q   <= alu_res;
				default: ;
			endcase
			if (uw.last) begin
				dsd_q <= ($signed(sat_res) > 0);
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'b0, dsd_q};

endmodule

`default_nettype wire

### src/fodsm_chk.sv
// Port-level checker for the delta-sigma modulator, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module fodsm_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata
);

	// Only one sample is in flight: the input closes after each request.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a sample is in progress");

	// A new result appears only at the end of a sample's program.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without a sample in progress");

	// The padding bits of the output are zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:1] == 7'b0))
		else $error("output padding bits are not zero");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output changed");

endmodule

bind fourth_order_delta_sigma_modulator fodsm_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
